/* rtl/plc_pkg.sv */
// Shared widths, codes and divider handshake types for the calibration core.
package plc_pkg;

  // Field widths of the transactions.
  localparam int COORD_W   = 16;
  localparam int COUNT_W   = 7;
  localparam int INDEX_W   = 6;
  localparam int VALUE_W   = 32;
  localparam int SLOPE_W   = 40;

  // Action codes of the command channel.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Divider geometry: a 33-bit magnitude shifted up by 16 fraction bits.
  localparam int DIV_W     = 49;
  localparam int STEP_W    = 6;
  localparam int VAL_STEPS = 49;
  localparam int SLP_STEPS = 32;
  localparam int REM_W     = 16;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // Response from the divider to the sequencer.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/plc_cmd_if.sv */
// Command channel: point writes and interpolation queries.
interface plc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [plc_pkg::INDEX_W-1:0]         point_index;
  logic signed [plc_pkg::COORD_W-1:0]  expected_value;
  logic signed [plc_pkg::COORD_W-1:0]  recorded_value;
  logic signed [plc_pkg::COORD_W-1:0]  target;

  modport source (output valid, action, point_index, expected_value, recorded_value, target,
                  input ready);
  modport sink   (input valid, action, point_index, expected_value, recorded_value, target,
                  output ready);
endinterface

/* rtl/plc_rsp_if.sv */
// Response channel: interpolated value and segment slope.
interface plc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                valid_res;
  logic signed [plc_pkg::VALUE_W-1:0]  value;
  logic signed [plc_pkg::SLOPE_W-1:0]  slope;

  modport source (output valid, valid_res, value, slope, input ready);
  modport sink   (input valid, valid_res, value, slope, output ready);
endinterface

/* rtl/plc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [WIDTH-1:0]                  wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [WIDTH-1:0]                  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/plc_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned dividend over a 16-bit divisor.
module plc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  plc_pkg::div_req_t             req,
  input  logic [plc_pkg::REM_W-1:0]     divisor,
  output plc_pkg::div_rsp_t             rsp
);

  logic                          busy;
  logic                          done;
  logic [plc_pkg::STEP_W-1:0]    cnt;
  logic [plc_pkg::REM_W-1:0]     rem;
  logic [plc_pkg::DIV_W-1:0]     quo;

  logic [plc_pkg::REM_W:0]       rem_sh;
  logic [plc_pkg::REM_W:0]       rem_sub;
  logic                          fits;

  // One trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_sh  = {rem, quo[plc_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = (rem_sh >= {1'b0, divisor});
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps - plc_pkg::STEP_W'(1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - plc_pkg::STEP_W'(1);
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[plc_pkg::REM_W-1:0] : rem_sh[plc_pkg::REM_W-1:0];
      quo <= {quo[plc_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/piecewise_linear_calibration_core.sv */
// Piecewise-linear calibration core: point table, breakpoint scan and fixed-point interpolation.
//
//   Channel  Direction  Handshake      Payload
//   cmd      in         valid/ready    action, point_index, expected_value,
//                                      recorded_value, target
//   rsp      out        valid/ready    valid_res, value, slope
//   cfg      in         cfg_we         cfg_wdata (point_count)
//
// A point write is done in its accept cycle. A query holds the core through the accept cycle,
// a table scan of every point in use through the RAM read port, drain, check, two passes of
// the shared 17x17 multiplier, a sum, the 49 and 32 steps of the shared bit-serial divider,
// and the load of the response. A query with fewer than two points in use goes from the accept
// cycle straight to the response load; one outside the x span goes there after scan, drain and
// check. Reset clears the sequencer, the response valid flag and point_count; the table is not
// cleared. The core takes no new command while a query runs; a finished response waits in its
// own register, new commands are taken while it waits, and a second finished query stalls in
// its last cycle until that register drains.
module piecewise_linear_calibration_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  plc_cmd_if.sink                          cmd,
  plc_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [plc_pkg::COUNT_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CW_ = plc_pkg::COORD_W;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_MUL1   = 4'd4;
  localparam logic [3:0] S_MUL2   = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_LDV    = 4'd7;
  localparam logic [3:0] S_WAITV  = 4'd8;
  localparam logic [3:0] S_WAITS  = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0]                     state;
  logic [plc_pkg::COUNT_W-1:0]    point_count;
  logic [AW-1:0]                  scan_cnt;
  logic                           rd_pend;
  logic signed [CW_-1:0]          tgt;
  logic                           lo_found;
  logic                           hi_found;
  logic                           below;
  logic signed [CW_-1:0]          lo_x;
  logic signed [CW_-1:0]          lo_y;
  logic signed [CW_-1:0]          hi_x;
  logic signed [CW_-1:0]          hi_y;
  logic signed [33:0]             prod_a;
  logic signed [33:0]             prod_b;
  logic signed [34:0]             acc;
  logic                           res_valid;
  logic signed [plc_pkg::VALUE_W-1:0] res_value;
  logic signed [plc_pkg::SLOPE_W-1:0] res_slope;
  logic                           rsp_valid;
  logic                           rsp_valid_res;
  logic signed [plc_pkg::VALUE_W-1:0] rsp_value;
  logic signed [plc_pkg::SLOPE_W-1:0] rsp_slope;

  logic [CW-1:0]                  n_used;
  logic [CW-1:0]                  last_idx;
  logic                           cmd_acc;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic                           rd_en;
  logic [2*CW_-1:0]               rd_data;
  logic signed [CW_-1:0]          rd_x;
  logic signed [CW_-1:0]          rd_y;
  logic signed [16:0]             dx_full;
  logic signed [16:0]             tdiff_full;
  logic signed [16:0]             dy;
  logic [16:0]                    dy_abs;
  logic signed [16:0]             mul_a;
  logic signed [16:0]             mul_b;
  logic signed [33:0]             mul_p;
  logic [34:0]                    acc_abs;
  logic                           load_rsp;
  logic [plc_pkg::VALUE_W-1:0]    q_val;
  logic [plc_pkg::SLOPE_W-1:0]    q_slp;
  plc_pkg::div_req_t              div_req;
  plc_pkg::div_rsp_t              div_rsp;

  // Points in use, limited to the table depth.
  always_comb begin
    if (32'(point_count) > 32'(MAX_POINTS)) begin
      n_used = CW'(MAX_POINTS);
    end else begin
      n_used = CW'(point_count);
    end
    last_idx = n_used - CW'(1);
  end

  // Command handshake and table write.
  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign wr_en     = cmd_acc && (cmd.action == plc_pkg::ACT_WRITE) &&
                     (32'(cmd.point_index) < 32'(MAX_POINTS));
  assign wr_addr   = AW'(32'(cmd.point_index));
  assign rd_en     = (state == S_SCAN);

  plc_ram #(
    .WIDTH (2 * CW_),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({cmd.expected_value, cmd.recorded_value}),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt),
    .rd_data (rd_data)
  );

  assign rd_x = rd_data[2*CW_-1:CW_];
  assign rd_y = rd_data[CW_-1:0];

  // Segment differences; dx and the target offset are never negative on a valid segment.
  always_comb begin
    dx_full    = {hi_x[CW_-1], hi_x} - {lo_x[CW_-1], lo_x};
    tdiff_full = {tgt[CW_-1], tgt} - {lo_x[CW_-1], lo_x};
    dy         = {hi_y[CW_-1], hi_y} - {lo_y[CW_-1], lo_y};
    dy_abs     = dy[16] ? (17'd0 - dy) : dy;
  end

  // Shared multiplier: y_lo * dx first, then dy * (target - x_lo).
  always_comb begin
    if (state == S_MUL1) begin
      mul_a = {lo_y[CW_-1], lo_y};
      mul_b = {1'b0, dx_full[15:0]};
    end else begin
      mul_a = dy;
      mul_b = {1'b0, tdiff_full[15:0]};
    end
    mul_p = mul_a * mul_b;
  end

  assign acc_abs = acc[34] ? (35'd0 - acc) : acc;

  // Divider requests: value dividend from the numerator, slope dividend from dy.
  always_comb begin
    div_req = '0;
    if (state == S_LDV) begin
      div_req.start    = 1'b1;
      div_req.dividend = {acc_abs[32:0], 16'd0};
      div_req.steps    = plc_pkg::STEP_W'(plc_pkg::VAL_STEPS);
    end else if ((state == S_WAITV) && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = {dy_abs[15:0], 16'd0, 17'd0};
      div_req.steps    = plc_pkg::STEP_W'(plc_pkg::SLP_STEPS);
    end
  end

  plc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .divisor (dx_full[15:0]),
    .rsp     (div_rsp)
  );

  // Signed results from the unsigned quotients, truncated toward zero.
  always_comb begin
    q_val = div_rsp.quotient[plc_pkg::VALUE_W-1:0];
    if (acc[34]) begin
      q_val = plc_pkg::VALUE_W'(0) - q_val;
    end
    q_slp = {8'd0, div_rsp.quotient[31:0]};
    if (dy[16]) begin
      q_slp = plc_pkg::SLOPE_W'(0) - q_slp;
    end
  end

  assign load_rsp = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
      rd_pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (cmd_acc && (cmd.action == plc_pkg::ACT_QUERY)) begin
            scan_cnt <= '0;
            if (n_used < CW'(2)) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pend  <= 1'b1;
          scan_cnt <= scan_cnt + AW'(1);
          if (scan_cnt == last_idx[AW-1:0]) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rd_pend <= 1'b0;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          if (below && hi_found) begin
            state <= S_MUL1;
          end else begin
            state <= S_FINISH;
          end
        end
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_SUM;
        S_SUM:   state <= S_LDV;
        S_LDV:   state <= S_WAITV;
        S_WAITV: begin
          if (div_rsp.done) begin
            state <= S_WAITS;
          end
        end
        S_WAITS: begin
          if (div_rsp.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_rsp) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Breakpoint tracking over the scanned points; a later equal x replaces the earlier one.
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      tgt      <= cmd.target;
      lo_found <= 1'b0;
      hi_found <= 1'b0;
      below    <= 1'b0;
    end else if (rd_pend) begin
      if (rd_x <= tgt) begin
        if (!lo_found || (rd_x >= lo_x)) begin
          lo_found <= 1'b1;
          lo_x     <= rd_x;
          lo_y     <= rd_y;
        end
        if (rd_x < tgt) begin
          below <= 1'b1;
        end
      end else begin
        if (!hi_found || (rd_x <= hi_x)) begin
          hi_found <= 1'b1;
          hi_x     <= rd_x;
          hi_y     <= rd_y;
        end
      end
    end
  end

  // Arithmetic datapath and result registers.
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      res_valid <= 1'b0;
      res_value <= '0;
      res_slope <= '0;
    end
    case (state)
      S_CHECK: begin
        if (below && hi_found) begin
          res_valid <= 1'b1;
        end
      end
      S_MUL1:  prod_a <= mul_p;
      S_MUL2:  prod_b <= mul_p;
      S_SUM:   acc    <= {prod_a[33], prod_a} + {prod_b[33], prod_b};
      S_WAITV: begin
        if (div_rsp.done) begin
          res_value <= q_val;
        end
      end
      S_WAITS: begin
        if (div_rsp.done) begin
          res_slope <= q_slp;
        end
      end
      default: begin
      end
    endcase
  end

  // Response output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_valid_res <= res_valid;
      rsp_value     <= res_value;
      rsp_slope     <= res_slope;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.valid_res = rsp_valid_res;
  assign rsp.value     = rsp_value;
  assign rsp.slope     = rsp_slope;

endmodule

/* tb/plc_checker.sv */
`timescale 1ns / 100ps
// Checker for the calibration core: mirrors the point table, predicts queries, checks responses.
module plc_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  plc_cmd_if                          cmd,
  plc_rsp_if                          rsp,
  input  logic                        cfg_we,
  input  logic [plc_pkg::COUNT_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          results_pending,
  output int                          queries_seen,
  output int                          inside_seen
);

  // One response transaction.
  typedef struct packed {
    logic                               valid_res;
    logic signed [plc_pkg::VALUE_W-1:0] value;
    logic signed [plc_pkg::SLOPE_W-1:0] slope;
  } calib_result_t;

  logic signed [plc_pkg::COORD_W-1:0] table_x [MAX_POINTS];
  logic signed [plc_pkg::COORD_W-1:0] table_y [MAX_POINTS];
  logic [plc_pkg::COUNT_W-1:0]        points_in_use;
  calib_result_t                      pending_answers[$];

  // Prints one line for each mismatch and counts it.
  task automatic report_mismatch(string what, logic signed [63:0] got,
                                 logic signed [63:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Interpolates the table at one target x, with the result zeroed when out of span.
  function automatic calib_result_t interpolate_point(logic signed [plc_pkg::COORD_W-1:0] tgt);
    calib_result_t r;
    int     n, i, lo, hi, xmin, xmax, xv, t;
    longint dx, dy, num;
    r = '0;
    t = int'(tgt);
    n = (points_in_use > MAX_POINTS) ? MAX_POINTS : int'(points_in_use);
    if (n < 2) return r;
    xmin = int'(table_x[0]);
    xmax = int'(table_x[0]);
    for (i = 1; i < n; i++) begin
      if (table_x[i] < xmin) xmin = int'(table_x[i]);
      if (table_x[i] > xmax) xmax = int'(table_x[i]);
    end
    if (!(t > xmin && t < xmax)) return r;
    // Lower breakpoint is the greatest x not above the target, upper the least above it.
    // Ties in x go to the highest index.
    lo = -1;
    hi = -1;
    for (i = 0; i < n; i++) begin
      xv = int'(table_x[i]);
      if (xv <= t) begin
        if (lo < 0 || xv >= table_x[lo]) lo = i;
      end else if (hi < 0 || xv <= table_x[hi]) begin
        hi = i;
      end
    end
    if (lo < 0 || hi < 0) return r;
    dx = longint'(table_x[hi]) - longint'(table_x[lo]);
    if (dx <= 0) return r;
    dy = longint'(table_y[hi]) - longint'(table_y[lo]);
    num = longint'(table_y[lo]) * dx * 65536
        + dy * (longint'(t) - longint'(table_x[lo])) * 65536;
    r.valid_res = 1'b1;
    r.value     = plc_pkg::VALUE_W'(num / dx);
    r.slope     = plc_pkg::SLOPE_W'((dy * 65536) / dx);
    return r;
  endfunction

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin : watch
    calib_result_t got, want;
    if (rst) begin
      points_in_use = '0;
      pending_answers.delete();
    end else begin
      if (cfg_we) points_in_use = cfg_wdata;

      // A response transaction is compared with the oldest waiting prediction.
      if (rsp.valid && rsp.ready) begin
        got.valid_res = rsp.valid_res;
        got.value     = rsp.value;
        got.slope     = rsp.slope;
        if (pending_answers.size() == 0) begin
          report_mismatch("response with no query waiting", 64'(got.value), 64'sd0);
        end else begin
          want = pending_answers.pop_front();
          if (got.valid_res !== want.valid_res)
            report_mismatch("valid_res", 64'(got.valid_res), 64'(want.valid_res));
          if (got.value !== want.value)
            report_mismatch("value", 64'(got.value), 64'(want.value));
          if (got.slope !== want.slope)
            report_mismatch("slope", 64'(got.slope), 64'(want.slope));
          if (want.valid_res) inside_seen++;
        end
      end

      // A command transaction either updates the table or queues a prediction.
      if (cmd.valid && cmd.ready) begin
        if (cmd.action == plc_pkg::ACT_WRITE) begin
          if (cmd.point_index < MAX_POINTS) begin
            table_x[cmd.point_index] = cmd.expected_value;
            table_y[cmd.point_index] = cmd.recorded_value;
          end
        end else begin
          pending_answers.push_back(interpolate_point(cmd.target));
          queries_seen++;
        end
      end
    end
    results_pending = pending_answers.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the calibration core testbench: clock, reset, stimulus, pacing and verdict.
module testbench;

  localparam int MAX_POINTS      = 64;
  localparam int NUM_ITEMS       = 900;
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_LIMIT     = 200000;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [plc_pkg::COUNT_W-1:0] cfg_wdata;

  plc_cmd_if cmd_ch();
  plc_rsp_if rsp_ch();

  int fail_count, results_pending, queries_seen, inside_seen;

  // Pacing knobs and stimulus bookkeeping.
  int send_idle_pct, recv_stall_pct, hold_request;
  int items_sent, writes_sent, phases_run, cur_count;
  bit point_written [MAX_POINTS];
  int shadow_x [MAX_POINTS];

  piecewise_linear_calibration_core #(
    .MAX_POINTS (MAX_POINTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  plc_checker #(
    .MAX_POINTS (MAX_POINTS)
  ) result_check (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd_ch),
    .rsp             (rsp_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .queries_seen    (queries_seen),
    .inside_seen     (inside_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs.
  initial begin
    #40_000_000;
    $display("piecewise_linear_calibration_core: mismatch");
    $finish;
  end

  // Response side: random stalls, plus one long hold-off counted here.
  initial begin : response_pacing
    int held;
    held = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (held < hold_request) begin
        rsp_ch.ready <= 1'b0;
        held++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  function automatic int in_use();
    return (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
  endfunction

  // Offers one command transaction and returns at the falling edge after it is taken.
  task automatic send_cmd(logic act, logic [plc_pkg::INDEX_W-1:0] idx,
                          logic signed [plc_pkg::COORD_W-1:0] x,
                          logic signed [plc_pkg::COORD_W-1:0] y,
                          logic signed [plc_pkg::COORD_W-1:0] tgt);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.action         <= act;
    cmd_ch.point_index    <= idx;
    cmd_ch.expected_value <= x;
    cmd_ch.recorded_value <= y;
    cmd_ch.target         <= tgt;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_point(int idx, logic signed [plc_pkg::COORD_W-1:0] x,
                             logic signed [plc_pkg::COORD_W-1:0] y);
    send_cmd(plc_pkg::ACT_WRITE, plc_pkg::INDEX_W'(idx), x, y, 16'($urandom));
    point_written[idx] = 1'b1;
    shadow_x[idx]      = x;
    writes_sent++;
  endtask

  // Unused fields of a query carry random bits.
  task automatic run_query(logic signed [plc_pkg::COORD_W-1:0] tgt);
    send_cmd(plc_pkg::ACT_QUERY, 6'($urandom), 16'($urandom), 16'($urandom), tgt);
  endtask

  // Lets every outstanding query finish, then lets the core settle.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_point_count(int n);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= plc_pkg::COUNT_W'(n);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_count = n;
    phases_run++;
  endtask

  // x coordinates: full range, a narrow cluster that forces ties, or the extremes, zero and random.
  function automatic logic signed [plc_pkg::COORD_W-1:0] gen_x(int style, int base);
    int v;
    case (style)
      0: v = $urandom_range(65535, 0) - 32768;
      1: v = base + $urandom_range(12, 0);
      default: begin
        case ($urandom_range(3, 0))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = $urandom_range(65535, 0) - 32768;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  function automatic logic signed [plc_pkg::COORD_W-1:0] gen_y();
    if ($urandom_range(9, 0) == 0) return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
    return 16'($urandom);
  endfunction

  // Targets: mostly inside the span, some on breakpoints, at the edges or anywhere.
  function automatic logic signed [plc_pkg::COORD_W-1:0] pick_target();
    int n, i, sel, t, lo_x, hi_x;
    n = in_use();
    sel = $urandom_range(99, 0);
    lo_x = 0;
    hi_x = 0;
    if (n > 0) begin
      lo_x = shadow_x[0];
      hi_x = shadow_x[0];
      for (i = 1; i < n; i++) begin
        if (shadow_x[i] < lo_x) lo_x = shadow_x[i];
        if (shadow_x[i] > hi_x) hi_x = shadow_x[i];
      end
    end
    if (n == 0 || sel < 10) begin
      t = $urandom_range(65535, 0) - 32768;
    end else if (sel < 25) begin
      t = shadow_x[$urandom_range(n - 1, 0)];
    end else if (sel < 40) begin
      case ($urandom_range(5, 0))
        0: t = lo_x;
        1: t = hi_x;
        2: t = lo_x - 1;
        3: t = hi_x + 1;
        4: t = -32768;
        default: t = 32767;
      endcase
    end else if (hi_x - lo_x >= 2) begin
      t = lo_x + 1 + $urandom_range(hi_x - lo_x - 2, 0);
    end else begin
      t = lo_x;
    end
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;
    return t[15:0];
  endfunction

  // Main stimulus.
  initial begin : stimulus
    int mode, style, base, new_count, n, k, i, nq, idx, sel, drain;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.action         = plc_pkg::ACT_WRITE;
    cmd_ch.point_index    = '0;
    cmd_ch.expected_value = '0;
    cmd_ch.recorded_value = '0;
    cmd_ch.target         = '0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_request          = 0;
    cur_count             = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: no points in use, then a single point.
    run_query(16'sd0);
    write_point(0, 16'sh8000, 16'sh8000);
    write_point(1, 16'sh7FFF, 16'sh7FFF);
    set_point_count(1);
    run_query(16'sd0);

    // Directed: widest segment, targets at and just inside its ends.
    set_point_count(2);
    run_query(16'sd0);
    run_query(16'sh8000);
    run_query(16'sh7FFF);
    run_query(-16'sd32767);
    run_query(16'sd32766);

    // Directed: a tie at x = 0, a target on an interior breakpoint, a flat segment.
    write_point(2, 16'sd0, 16'sd100);
    write_point(3, 16'sd0, -16'sd200);
    write_point(4, 16'sd100, 16'sh7FFF);
    set_point_count(5);
    run_query(16'sd0);
    run_query(16'sd50);
    run_query(-16'sd1);
    run_query(16'sd100);
    run_query(16'sd99);

    // Directed: a tie at the top end of the span.
    write_point(5, 16'sh7FFF, 16'sd0);
    set_point_count(6);
    run_query(16'sd32766);
    run_query(16'sd101);

    // Random phases, each a fresh table setting and a pacing mode.
    while (items_sent < NUM_ITEMS) begin
      mode = phases_run % 4;
      send_idle_pct  = (mode == 1) ? 55 : (mode == 3) ? 16 : 0;
      recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 16 : 0;
      style = $urandom_range(2, 0);
      base  = $urandom_range(65535 - 12, 0) - 32768;

      sel = $urandom_range(99, 0);
      if (phases_run == 5) new_count = MAX_POINTS;
      else if (phases_run == 10) new_count = 127;
      else if (sel < 8) new_count = $urandom_range(1, 0);
      else if (sel < 16) new_count = $urandom_range(MAX_POINTS, 20);
      else if (sel < 20) new_count = $urandom_range(127, MAX_POINTS + 1);
      else new_count = $urandom_range(10, 2);
      n = (new_count > MAX_POINTS) ? MAX_POINTS : new_count;

      // Refresh a few points, then make sure every entry in use has been written.
      k = $urandom_range((n < 8) ? n : 8, 0);
      for (i = 0; i < k; i++) begin
        write_point($urandom_range((n < 2) ? 1 : n - 1, 0), gen_x(style, base), gen_y());
      end
      for (i = 0; i < n; i++) begin
        if (!point_written[i]) write_point(i, gen_x(style, base), gen_y());
      end
      set_point_count(new_count);

      // One phase holds the response side off so the core backs up its input.
      if (phases_run == 8) hold_request = HOLD_OFF_CYCLES;

      nq = $urandom_range(20, 8);
      for (i = 0; i < nq; i++) begin
        if ($urandom_range(99, 0) < 12) begin
          idx = (n > 0 && $urandom_range(1, 0)) ? $urandom_range(n - 1, 0)
                                                : $urandom_range(MAX_POINTS - 1, 0);
          write_point(idx, gen_x(style, base), gen_y());
        end else begin
          run_query(pick_target());
        end
      end
    end

    // Drain the outstanding queries and let the core settle.
    cmd_ch.valid <= 1'b0;
    drain = 0;
    while (results_pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d point writes and %0d queries, %0d of them inside the span,",
             writes_sent, queries_seen, inside_seen);
    $display("over %0d point-count settings with mixed handshake pacing and a long hold-off.",
             phases_run);
    if (fail_count == 0 && results_pending == 0) begin
      $display("piecewise_linear_calibration_core: match");
    end else begin
      $display("piecewise_linear_calibration_core: mismatch");
    end
    $finish;
  end

endmodule
